[rtl/fcw_pkg.sv]
// Shared types, widths and codes for the FAT12 cluster chain walker.
package fcw_pkg;

  localparam int FAT_BYTES    = 512;
  localparam int FAT_AW       = $clog2(FAT_BYTES);
  localparam int MAX_CLUSTERS = 128;

  localparam int CLUSTER_W = 12;
  localparam int SLOT_W    = 7;
  localparam int LBA_W     = 16;
  localparam int SPT_W     = 6;
  localparam int SPC_W     = 8;
  localparam int COPIES_W  = 8;
  localparam int CYL_W     = 15;
  localparam int OFF_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFFF;
  localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(MAX_CLUSTERS - 1);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_END  = 2'd1,
    ST_LONG = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COPIES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPF      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPC      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPT      = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FSEC  = 6'b000010,
    S_LBA   = 6'b000100,
    S_DIVGO = 6'b001000,
    S_DIVW  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

endpackage

[rtl/fcw_div.sv]
// Restoring divider, one quotient bit per cycle, for sector address over sectors per track.
module fcw_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fcw_pkg::LBA_W-1:0]   dividend,
  input  logic [fcw_pkg::SPT_W-1:0]   divisor,
  output logic                        busy,
  output logic [fcw_pkg::LBA_W-1:0]   quotient,
  output logic [fcw_pkg::SPT_W-1:0]   remainder
);
  import fcw_pkg::*;

  localparam int CNT_W = $clog2(LBA_W + 1);

  logic [CNT_W-1:0] count;
  logic [SPT_W:0]   rem_sh;
  logic             q_bit;
  logic [SPT_W:0]   rem_sub;

  assign rem_sh  = {remainder, quotient[LBA_W-1]};
  assign q_bit   = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(LBA_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[LBA_W-2:0], q_bit};
      remainder <= q_bit ? rem_sub[SPT_W-1:0] : rem_sh[SPT_W-1:0];
    end
  end

endmodule

[rtl/fat12_cluster_chain_walker.sv]
// FAT12 cluster chain walker: table store, sector address, CHS conversion and chain decode.
//
//  channel | direction | contents
//  s_*     | in        | tuser: op; tdata: fat_addr, fat_data, start_cluster
//  m_*     | out       | tdata: cluster .. status; tlast: end of chain
//  cfg_*   | in        | register write, index 0..5
//
// Write, start and idle steps complete in the idle state. A walking step uses
// the shared 16x8 multiplier twice, then the one-bit-per-cycle divider.
// The FAT store is read twice through its single port during the multiplies.
// Reset (synchronous) loads the register defaults and stops the walk; the store
// is not cleared. A stalled result holds in the output register; writes and
// starts are still taken meanwhile.
module fat12_cluster_chain_walker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // fat_addr[12:0], fat_data[20:13], start_cluster[32:21], zero fill
  input  logic [fcw_pkg::IN_DATA_W-1:0]     s_tdata,
  // op[1:0]
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // cluster[11:0], load_slot[18:12], cylinder[33:19], head[34],
  // sector_number[40:35], status[42:41], zero fill
  output logic [fcw_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [fcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcw_pkg::CFG_W-1:0]         cfg_data
);
  import fcw_pkg::*;

  logic [15:0]          reserved_sectors;
  logic [COPIES_W-1:0]  fat_copies;
  logic [15:0]          sectors_per_fat;
  logic [15:0]          root_entries;
  logic [SPC_W-1:0]     clus_sectors;
  logic [SPT_W-1:0]     track_sectors;

  state_t               state;
  logic [CLUSTER_W-1:0] current_cluster;
  logic [SLOT_W-1:0]    slot_count;
  logic                 walking;
  logic [LBA_W-1:0]     acc;
  logic [7:0]           lo_byte;
  logic [7:0]           rd_data;
  logic [7:0]           fat_mem [FAT_BYTES];

  logic                 in_acc;
  op_t                  op;
  logic [OFF_W-1:0]     fat_addr;
  logic [7:0]           fat_data;
  logic [CLUSTER_W-1:0] start_cluster;
  logic                 wr_en;

  logic [OFF_W-1:0]     off;
  logic                 bad;
  logic [FAT_AW-1:0]    rd_addr;
  logic [15:0]          mul_a;
  logic [SPC_W-1:0]     mul_b;
  logic [23:0]          mul_p;
  logic [SPT_W-1:0]     spt_eff;

  logic                 div_start;
  logic                 div_busy;
  logic [LBA_W-1:0]     track;
  logic [SPT_W-1:0]     sec_rem;

  logic [15:0]          word;
  logic [CLUSTER_W-1:0] next_cluster;
  status_t              status_next;

  assign in_acc        = s_tvalid && s_tready;
  assign op            = op_t'(s_tuser);
  assign fat_addr      = s_tdata[12:0];
  assign fat_data      = s_tdata[20:13];
  assign start_cluster = s_tdata[32:21];
  assign s_tready      = (state == S_IDLE);
  assign wr_en = in_acc && (op == OP_WRITE) && ({1'b0, fat_addr} < 14'(FAT_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_sectors <= 16'd1;
      fat_copies       <= 8'd2;
      sectors_per_fat  <= 16'd9;
      root_entries     <= 16'd224;
      clus_sectors     <= 8'd1;
      track_sectors    <= 6'd18;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESERVED: reserved_sectors <= cfg_data;
        REG_COPIES:   fat_copies       <= cfg_data[COPIES_W-1:0];
        REG_SPF:      sectors_per_fat  <= cfg_data;
        REG_ROOT:     root_entries     <= cfg_data;
        REG_SPC:      clus_sectors     <= cfg_data[SPC_W-1:0];
        REG_SPT:      track_sectors    <= cfg_data[SPT_W-1:0];
        default: ;
      endcase
    end
  end

  // entry byte offset = cluster * 3 / 2
  assign off     = OFF_W'(current_cluster) + OFF_W'(current_cluster[CLUSTER_W-1:1]);
  assign bad     = ({1'b0, off} + 14'd1) >= 14'(FAT_BYTES);
  assign rd_addr = (state == S_FSEC) ? off[FAT_AW-1:0] : off[FAT_AW-1:0] + FAT_AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fat_mem[fat_addr[FAT_AW-1:0]] <= fat_data;
    end
    if (state == S_FSEC || state == S_LBA) begin
      rd_data <= fat_mem[rd_addr];
    end
  end

  // shared multiplier: FAT area size, then cluster offset
  always_comb begin
    if (state == S_FSEC) begin
      mul_a = sectors_per_fat;
      mul_b = fat_copies;
    end else begin
      mul_a = {4'd0, current_cluster} - 16'd2;
      mul_b = clus_sectors;
    end
  end
  assign mul_p   = mul_a * mul_b;
  assign spt_eff = (track_sectors == '0) ? SPT_W'(1) : track_sectors;

  assign div_start = (state == S_DIVGO);

  fcw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (acc),
    .divisor   (spt_eff),
    .busy      (div_busy),
    .quotient  (track),
    .remainder (sec_rem)
  );

  assign word         = {rd_data, lo_byte};
  assign next_cluster = current_cluster[0] ? word[15:4] : word[11:0];

  always_comb begin
    if (bad) begin
      status_next = ST_BAD;
    end else if (next_cluster == END_MARK) begin
      status_next = ST_END;
    end else if (slot_count == LAST_SLOT) begin
      status_next = ST_LONG;
    end else begin
      status_next = ST_MORE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      current_cluster <= '0;
      slot_count      <= '0;
      walking         <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && op == OP_START) begin
            current_cluster <= start_cluster;
            slot_count      <= '0;
            walking         <= 1'b1;
          end else if (in_acc && op == OP_STEP && walking) begin
            state <= S_FSEC;
          end
        end
        S_FSEC: begin
          acc   <= reserved_sectors + {4'd0, root_entries[15:4]} + mul_p[15:0];
          state <= S_LBA;
        end
        S_LBA: begin
          acc     <= acc + mul_p[15:0];
          lo_byte <= rd_data;
          state   <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (!div_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tlast  <= (status_next != ST_MORE);
            m_tdata  <= {5'd0, status_next, SPT_W'(sec_rem + SPT_W'(1)), track[0],
                         track[CYL_W:1], slot_count, current_cluster};
            if (status_next == ST_MORE) begin
              current_cluster <= next_cluster;
              slot_count      <= slot_count + SLOT_W'(1);
            end else begin
              walking <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_last_matches_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[42:41] != ST_MORE)))
    else $error("tlast disagrees with status");

  a_step_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == OP_STEP && walking) |=> (state == S_FSEC))
    else $error("step while walking did not start the sequence");

  a_out_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !div_busy)
    else $error("result taken while divider busy");

  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(m_tvalid)) |-> ($past(state) == S_OUT))
    else $error("result beat raised outside the output state");

  a_walk_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(walking)) |-> (m_tvalid && m_tlast))
    else $error("walk stopped without a last beat");

endmodule
